FILE: hdl/greenhouse_climate_controller_macros.svh
// Assertion macros shared by the greenhouse climate controller modules.
`ifndef GREENHOUSE_CLIMATE_CONTROLLER_MACROS_SVH
`define GREENHOUSE_CLIMATE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GCC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gcc_pkg.sv
// Types, constants and helper functions of the greenhouse climate controller.
package gcc_pkg;

    // field widths
    localparam int NowW   = 32;
    localparam int TempW  = 11;
    localparam int LevelW = 10;
    localparam int HourW  = 5;
    localparam int QuotW  = 11;
    localparam int IdxW   = 3;
    localparam int CfgW   = 11;

    // stream packing
    localparam int InDataW   = 80;
    localparam int InFieldsW = 73;
    localparam int InUserW   = 2;
    localparam int OutDataW  = 48;
    localparam int OutFieldsW = 41;

    localparam int NowLsb   = 0;
    localparam int TempLsb  = NowLsb + NowW;
    localparam int HumLsb   = TempLsb + TempW;
    localparam int SoilLsb  = HumLsb + LevelW;
    localparam int LightLsb = SoilLsb + LevelW;

    localparam int UserTempOk = 0;
    localparam int UserHumOk  = 1;

    localparam int OutHeater    = 0;
    localparam int OutFan       = 1;
    localparam int OutPump      = 2;
    localparam int OutLamp      = 3;
    localparam int OutStartLsb  = 4;
    localparam int OutHourLsb   = OutStartLsb + NowW;

    // now_ms / 3600000 = (now_ms >> 7) / 28125, done as a reciprocal multiply.
    // Magic = ceil(2^40 / 28125); exact for every 25-bit dividend.
    localparam int DivShift   = 7;
    localparam int ScaledW    = NowW - DivShift;
    localparam int MagicW     = 26;
    localparam int ProdW      = ScaledW + MagicW;
    localparam int MagicShift = 40;
    localparam logic [MagicW-1:0] HourMagic = 26'd39093747;

    // w / 3 = (w * 171) >> 9 for w below 512
    localparam int Div3ProdW = 16;
    localparam int Div3Shift = 9;
    localparam logic [Div3ProdW-1:0] Div3Magic = 16'd171;

    localparam logic [QuotW-1:0] FirstHour  = 11'd8;
    localparam logic [HourW-1:0] NightFrom  = 5'd22;
    localparam logic [HourW-1:0] NightUntil = 5'd6;
    localparam logic [HourW-1:0] VentFrom   = 5'd10;
    localparam logic [HourW-1:0] VentUntil  = 5'd14;
    localparam logic [HourW-1:0] HoursPerDay = 5'd24;

    localparam logic [NowW-1:0] StartupFanMs = 32'd5000;
    localparam logic [NowW-1:0] AfterHeatMs  = 32'd2000;

    localparam logic signed [TempW-1:0] TempDefault = 11'sd200;
    localparam logic [LevelW-1:0]       HumDefault  = 10'd500;

    typedef enum logic [IdxW-1:0] {
        REG_TEMP_MIN     = 3'd0,
        REG_TEMP_MAX     = 3'd1,
        REG_HUMIDITY_MAX = 3'd2,
        REG_SOIL_DRY     = 3'd3,
        REG_SOIL_WET     = 3'd4,
        REG_LIGHT_DARK   = 3'd5,
        REG_LIGHT_BRIGHT = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [TempW-1:0] temp_min;
        logic signed [TempW-1:0] temp_max;
        logic [LevelW-1:0]       humidity_max;
        logic [LevelW-1:0]       soil_dry;
        logic [LevelW-1:0]       soil_wet;
        logic [LevelW-1:0]       light_dark;
        logic [LevelW-1:0]       light_bright;
    } cfg_t;

    // one control step after input cleanup and the hour divide
    typedef struct packed {
        logic [NowW-1:0]         now_ms;
        logic signed [TempW-1:0] temperature;
        logic [LevelW-1:0]       humidity;
        logic [LevelW-1:0]       soil;
        logic [LevelW-1:0]       dark;
        logic [QuotW-1:0]        hours;
    } item_t;

    typedef struct packed {
        logic             heater_cmd;
        logic             fan_on;
        logic             pump_on;
        logic             lamp_on;
        logic [NowW-1:0]  pump_start_ms;
        logic [HourW-1:0] hour_of_day;
    } result_t;

    // (FirstHour + hours) mod 24, split as mod 8 and mod 3 of the upper bits
    function automatic logic [HourW-1:0] hour_from_quot(input logic [QuotW-1:0] hours);
        logic [QuotW-1:0]     v;
        logic [7:0]           w;
        logic [Div3ProdW-1:0] p;
        logic [7:0]           q3;
        logic [7:0]           r3;
        v  = hours + FirstHour;
        w  = v[QuotW-1:3];
        p  = Div3ProdW'(w) * Div3Magic;
        q3 = 8'(p >> Div3Shift);
        r3 = w - q3 * 8'd3;
        return {r3[1:0], v[2:0]};
    endfunction

endpackage

FILE: hdl/gcc_ctrl_core.sv
// Control state of the greenhouse controller: heater, fan, pump and lamp decisions.
`include "greenhouse_climate_controller_macros.svh"

module gcc_ctrl_core
    import gcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    // heater_state doubles as the previous heater command: both change together.
    logic            heater_state_reg, heater_next;
    logic            pump_state_reg, pump_next;
    logic            lamp_state_reg, lamp_next;
    logic            startup_done_reg, startup_done_next;
    logic            hold_reg, hold_next;
    logic [NowW-1:0] heater_off_reg, heater_off_next;
    logic [NowW-1:0] pump_start_reg, pump_start_next;

    logic [HourW-1:0] hour;
    logic             night;
    logic             vent;
    logic             hot;
    logic             fan;
    logic [NowW-1:0]  elapsed;

    always_comb
    begin
        hour  = hour_from_quot(item.hours);
        night = (hour >= NightFrom) || (hour < NightUntil);
        vent  = (hour >= VentFrom) && (hour < VentUntil);
        hot   = $signed(item.temperature) >= $signed(cfg.temp_max);

        priority if ($signed(item.temperature) <= $signed(cfg.temp_min))
            heater_next = 1'b1;
        else if (hot)
            heater_next = 1'b0;
        else
            heater_next = heater_state_reg;

        fan = 1'b0;
        startup_done_next = startup_done_reg;
        if (!startup_done_reg)
        begin
            if (item.now_ms < StartupFanMs)
                fan = 1'b1;
            else
                startup_done_next = 1'b1;
        end
        if (hot || (item.humidity > cfg.humidity_max) || (!night && vent) || heater_next)
            fan = 1'b1;

        // after-heat hold starts on the on-to-off edge of the heater
        hold_next       = hold_reg;
        heater_off_next = heater_off_reg;
        if (heater_state_reg && !heater_next)
        begin
            hold_next       = 1'b1;
            heater_off_next = item.now_ms;
        end
        elapsed = item.now_ms - heater_off_next;
        if (hold_next)
        begin
            if (elapsed < AfterHeatMs)
                fan = 1'b1;
            else
                hold_next = 1'b0;
        end

        pump_start_next = pump_start_reg;
        priority if (item.soil < cfg.soil_dry)
        begin
            if (!pump_state_reg)
                pump_start_next = item.now_ms;
            pump_next = 1'b1;
        end
        else if (item.soil > cfg.soil_wet)
            pump_next = 1'b0;
        else
            pump_next = pump_state_reg;

        priority if (night)
            lamp_next = 1'b0;
        else if (item.dark > cfg.light_dark)
            lamp_next = 1'b1;
        else if (item.dark < cfg.light_bright)
            lamp_next = 1'b0;
        else
            lamp_next = lamp_state_reg;

        result.heater_cmd    = heater_next;
        result.fan_on        = fan;
        result.pump_on       = pump_next;
        result.lamp_on       = lamp_next;
        result.pump_start_ms = pump_start_next;
        result.hour_of_day   = hour;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_state_reg <= 1'b0;
            pump_state_reg   <= 1'b0;
            lamp_state_reg   <= 1'b0;
            startup_done_reg <= 1'b0;
            hold_reg         <= 1'b0;
            heater_off_reg   <= '0;
            pump_start_reg   <= '0;
        end
        else if (load)
        begin
            heater_state_reg <= heater_next;
            pump_state_reg   <= pump_next;
            lamp_state_reg   <= lamp_next;
            startup_done_reg <= startup_done_next;
            hold_reg         <= hold_next;
            heater_off_reg   <= heater_off_next;
            pump_start_reg   <= pump_start_next;
        end
    end

    `GCC_ASSERT_NEXT(a_pump_start_latch, load && !pump_state_reg && (item.soil < cfg.soil_dry), pump_start_reg == $past(item.now_ms), "pump start time not latched on pump turn-on")

    `GCC_ASSERT_NEXT(a_heat_off_hold, load && heater_state_reg && !heater_next, hold_reg && (heater_off_reg == $past(item.now_ms)), "after-heat hold not armed on heater turn-off")

endmodule

FILE: hdl/greenhouse_climate_controller.sv
// Top level of the greenhouse climate controller: stream ports, registers, pipeline.
`include "greenhouse_climate_controller_macros.svh"

// Greenhouse climate controller. Each input transaction is one control step:
// a millisecond timestamp plus sensor readings. Each step yields exactly one
// output transaction with the heater, fan, pump and lamp commands, the latched
// pump start time and the hour of day. The block takes one transaction per
// cycle while the output side keeps taking results. Stage one registers the
// raw transaction; stage two replaces invalid temperature (20.0) and humidity
// (50.0) readings, inverts light into darkness and runs the whole-hour divide
// as a 25 x 26 bit reciprocal multiply; stage three forms the hour of day and
// updates the controller state, and its result sits in the output register.
// A stage holds only while the one after it is full and not moving, so a stall
// starts at a full output register that is not taken; empty stages ahead of it
// still fill and keep taking new transactions. Configuration registers are written
// through cfg_wr_en / cfg_index / cfg_data with no read-back; write them only
// while no transaction is in flight. Index 7 is ignored. No clearing pass is
// needed after reset.
module greenhouse_climate_controller
    import gcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // now_ms[31:0], temperature[42:32], humidity[52:43], soil_raw[62:53],
    // light_raw[72:63], zero fill[79:73]
    input  logic [InDataW-1:0]  s_axis_tdata,
    // temperature_ok[0], humidity_ok[1]
    input  logic [InUserW-1:0]  s_axis_tuser,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // heater_cmd[0], fan_on[1], pump_on[2], lamp_on[3], pump_start_ms[35:4],
    // hour_of_day[40:36], zero fill[47:41]
    output logic [OutDataW-1:0] m_axis_tdata,

    input  logic                cfg_wr_en,
    input  logic [IdxW-1:0]     cfg_index,
    input  logic [CfgW-1:0]     cfg_data
);

    cfg_t cfg_reg;

    logic                 s0_valid_reg;
    logic [InFieldsW-1:0] s0_data_reg;
    logic [InUserW-1:0]   s0_user_reg;

    logic  s1_valid_reg;
    item_t s1_item_reg;
    item_t s1_next;

    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;

    logic load_s0;
    logic load_s1;
    logic load_out;

    logic [ScaledW-1:0] scaled;
    logic [ProdW-1:0]   prod;

    // pipeline flow: a stage moves when the one after it is empty or moving
    assign load_out      = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign load_s1       = s0_valid_reg && (!s1_valid_reg || load_out);
    assign s_axis_tready = !s0_valid_reg || load_s1;
    assign load_s0       = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_min     <= 11'sd260;
            cfg_reg.temp_max     <= 11'sd270;
            cfg_reg.humidity_max <= 10'd600;
            cfg_reg.soil_dry     <= 10'd400;
            cfg_reg.soil_wet     <= 10'd500;
            cfg_reg.light_dark   <= 10'd200;
            cfg_reg.light_bright <= 10'd500;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TEMP_MIN:     cfg_reg.temp_min     <= cfg_data;
                REG_TEMP_MAX:     cfg_reg.temp_max     <= cfg_data;
                REG_HUMIDITY_MAX: cfg_reg.humidity_max <= cfg_data[LevelW-1:0];
                REG_SOIL_DRY:     cfg_reg.soil_dry     <= cfg_data[LevelW-1:0];
                REG_SOIL_WET:     cfg_reg.soil_wet     <= cfg_data[LevelW-1:0];
                REG_LIGHT_DARK:   cfg_reg.light_dark   <= cfg_data[LevelW-1:0];
                REG_LIGHT_BRIGHT: cfg_reg.light_bright <= cfg_data[LevelW-1:0];
                default:          ;
            endcase
        end
    end

    // stage two: input cleanup and whole hours of the timestamp
    always_comb
    begin
        scaled = s0_data_reg[NowLsb + NowW - 1 -: ScaledW];
        prod   = ProdW'(scaled) * ProdW'(HourMagic);

        s1_next.now_ms      = s0_data_reg[NowLsb +: NowW];
        s1_next.temperature = s0_user_reg[UserTempOk] ?
                              s0_data_reg[TempLsb +: TempW] : TempDefault;
        s1_next.humidity    = s0_user_reg[UserHumOk] ?
                              s0_data_reg[HumLsb +: LevelW] : HumDefault;
        s1_next.soil        = s0_data_reg[SoilLsb +: LevelW];
        // 1023 - light is the bitwise complement of a 10-bit value
        s1_next.dark        = ~s0_data_reg[LightLsb +: LevelW];
        s1_next.hours       = prod[MagicShift +: QuotW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s0_valid_reg <= s_axis_tvalid;
            if (!s1_valid_reg || load_out)
                s1_valid_reg <= s0_valid_reg;
            if (!out_valid_reg || m_axis_tready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s0)
        begin
            s0_data_reg <= s_axis_tdata[InFieldsW-1:0];
            s0_user_reg <= s_axis_tuser;
        end
        if (load_s1)
            s1_item_reg <= s1_next;
        if (load_out)
            out_reg <= core_result;
    end

    // stage three: hour of day and controller state
    gcc_ctrl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_out),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[OutHeater] = out_reg.heater_cmd;
        m_axis_tdata[OutFan]    = out_reg.fan_on;
        m_axis_tdata[OutPump]   = out_reg.pump_on;
        m_axis_tdata[OutLamp]   = out_reg.lamp_on;
        m_axis_tdata[OutStartLsb +: NowW] = out_reg.pump_start_ms;
        m_axis_tdata[OutHourLsb +: HourW] = out_reg.hour_of_day;
    end

    `GCC_ASSERT_IMPLIES(a_hour_range, out_valid_reg, out_reg.hour_of_day < HoursPerDay, "hour of day out of range")

    `GCC_ASSERT_IMPLIES(a_night_lamp_off, out_valid_reg && ((out_reg.hour_of_day >= NightFrom) || (out_reg.hour_of_day < NightUntil)), !out_reg.lamp_on, "lamp on at night")

    `GCC_ASSERT_IMPLIES(a_heater_fan, out_valid_reg && out_reg.heater_cmd, out_reg.fan_on, "heater on without fan")

    `GCC_ASSERT_NEXT(a_stall_hold, out_valid_reg && !m_axis_tready && s1_valid_reg, s1_valid_reg && out_valid_reg, "pipeline dropped a transaction while stalled")

endmodule

FILE: sim/tb.sv
// Stream-level testbench for the greenhouse climate controller with a built-in predictor.
module tb;
    import gcc_pkg::*;

    // ------------------------------------------------------------------
    // Timing of the run
    // ------------------------------------------------------------------
    localparam int          HalfPeriod  = 6;
    localparam int          ResetCycles = 11;
    localparam int          DrainCycles = 6;      // pipeline is three deep
    localparam int          QuietLimit  = 2000;   // cycles with no transaction at all
    localparam int          HoldAt      = 60;     // result count that starts the long stall
    localparam int unsigned HoldCycles  = 300;
    localparam int          PhaseSteps  = 85;
    localparam int          PhaseCount  = 6;
    localparam int unsigned MaxIdle     = 14;

    // ------------------------------------------------------------------
    // Controller constants, kept apart from the package on purpose
    // ------------------------------------------------------------------
    localparam logic [31:0] HourMs      = 32'd3600000;
    localparam logic [31:0] HourOffset  = 32'd8;
    localparam logic [31:0] WarmupMs    = 32'd5000;
    localparam logic [31:0] CoolDownMs  = 32'd2000;
    localparam logic [4:0]  NightBegin  = 5'd22;
    localparam logic [4:0]  NightEnd    = 5'd6;
    localparam logic [4:0]  VentBegin   = 5'd10;
    localparam logic [4:0]  VentEnd     = 5'd14;
    localparam int          TempSubst   = 200;
    localparam logic [9:0]  HumSubst    = 10'd500;
    localparam logic [9:0]  LightFull   = 10'd1023;
    localparam logic [2:0]  RegSpare    = 3'd7;   // unmapped index, must be ignored

    // one control step as offered on the input stream
    typedef struct {
        logic [31:0]        now_ms;
        logic signed [10:0] temperature;
        logic               temperature_ok;
        logic [9:0]         humidity;
        logic               humidity_ok;
        logic [9:0]         soil_raw;
        logic [9:0]         light_raw;
        int unsigned        gap;     // idle cycles the sender waits after this one
    } step_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // now_ms[31:0], temperature[42:32], humidity[52:43], soil_raw[62:53],
    // light_raw[72:63], zero fill[79:73]
    logic [InDataW-1:0]  s_axis_tdata = '0;
    // temperature_ok[0], humidity_ok[1]
    logic [InUserW-1:0]  s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // heater_cmd[0], fan_on[1], pump_on[2], lamp_on[3], pump_start_ms[35:4],
    // hour_of_day[40:36], zero fill[47:41]
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_wr_en = 1'b0;
    logic [IdxW-1:0]     cfg_index = '0;
    logic [CfgW-1:0]     cfg_data = '0;

    wire s_fire = s_axis_tvalid && s_axis_tready;
    wire m_fire = m_axis_tvalid && m_axis_tready;

    greenhouse_climate_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: threshold shadow and controller memory, reset values
    // ------------------------------------------------------------------
    int         lim_temp_lo = 260;
    int         lim_temp_hi = 270;
    logic [9:0] lim_hum     = 10'd600;
    logic [9:0] lim_dry     = 10'd400;
    logic [9:0] lim_wet     = 10'd500;
    logic [9:0] lim_dark    = 10'd200;
    logic [9:0] lim_bright  = 10'd500;

    bit          heat_on       = 1'b0;
    bit          heat_was      = 1'b0;
    bit          hold_on       = 1'b0;
    bit          warmup_done   = 1'b0;
    bit          pump_run      = 1'b0;
    bit          lamp_lit      = 1'b0;
    logic [31:0] heat_off_ms   = '0;
    logic [31:0] pump_since_ms = '0;

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    step_t       step_queue[$];    // steps waiting to be offered
    result_t     cmd_due[$];       // predicted commands, oldest first
    step_t       offer;            // step currently on the input bus
    int unsigned tx_idle = 0;
    bit          tx_calm = 1'b0;   // stretch with no sender gaps
    int unsigned rx_wait = 0;
    bit          rx_calm = 1'b0;   // stretch with no receiver stalls
    int          steps_taken = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    logic [31:0] wall_ms = '0;     // running timestamp for the random steps

    // One control step: returns the commands and advances the controller memory.
    function automatic result_t climate_step(input step_t s);
        result_t     r;
        int          t;
        logic [9:0]  hum;
        logic [9:0]  dark;
        logic [31:0] hours;
        logic [4:0]  hr;
        bit          night;
        bit          vent;
        bit          fan;
        t     = s.temperature_ok ? int'(s.temperature) : TempSubst;
        hum   = s.humidity_ok ? s.humidity : HumSubst;
        dark  = LightFull - s.light_raw;
        hours = HourOffset + s.now_ms / HourMs;
        hr    = 5'(hours % 32'd24);
        night = (hr >= NightBegin) || (hr < NightEnd);
        vent  = (hr >= VentBegin) && (hr < VentEnd);
        fan   = 1'b0;

        // heater: on test first, so crossed limits favor heating
        if (t <= lim_temp_lo)
            heat_on = 1'b1;
        else if (t >= lim_temp_hi)
            heat_on = 1'b0;

        // start-up run ends for good at the first step past the window
        if (!warmup_done)
        begin
            if (s.now_ms < WarmupMs)
                fan = 1'b1;
            else
                warmup_done = 1'b1;
        end
        if (t >= lim_temp_hi)
            fan = 1'b1;
        if (hum > lim_hum)
            fan = 1'b1;
        if (!night && vent)
            fan = 1'b1;
        if (heat_on)
            fan = 1'b1;

        // after-heat run, elapsed time wraps mod 2^32
        if (heat_was && !heat_on)
        begin
            hold_on     = 1'b1;
            heat_off_ms = s.now_ms;
        end
        if (hold_on)
        begin
            if (s.now_ms - heat_off_ms < CoolDownMs)
                fan = 1'b1;
            else
                hold_on = 1'b0;
        end
        heat_was = heat_on;

        // pump: dry test first, start time latched on the off-to-on edge
        if (s.soil_raw < lim_dry)
        begin
            if (!pump_run)
                pump_since_ms = s.now_ms;
            pump_run = 1'b1;
        end
        else if (s.soil_raw > lim_wet)
            pump_run = 1'b0;

        // lamp: dark at night, otherwise on test first
        if (night)
            lamp_lit = 1'b0;
        else if (dark > lim_dark)
            lamp_lit = 1'b1;
        else if (dark < lim_bright)
            lamp_lit = 1'b0;

        r.heater_cmd    = heat_on;
        r.fan_on        = fan;
        r.pump_on       = pump_run;
        r.lamp_on       = lamp_lit;
        r.pump_start_ms = pump_since_ms;
        r.hour_of_day   = hr;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever
            #HalfPeriod clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued steps, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                cmd_due.push_back(climate_step(offer));
                steps_taken++;
            end
            // bus is free after this edge unless a step is still waiting on tready
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_idle != 0)
                begin
                    tx_idle--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (step_queue.size() != 0)
                begin
                    offer   = step_queue.pop_front();
                    tx_idle = offer.gap;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, offer.light_raw, offer.soil_raw, offer.humidity,
                                      offer.temperature, offer.now_ms};
                    s_axis_tuser  <= {offer.humidity_ok, offer.temperature_ok};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results, random stalls plus one long hold-off that
    // lets the pipeline fill and push back on the input side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : rx_side
        result_t got;
        result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_fire)
            begin
                got.heater_cmd    = m_axis_tdata[0];
                got.fan_on        = m_axis_tdata[1];
                got.pump_on       = m_axis_tdata[2];
                got.lamp_on       = m_axis_tdata[3];
                got.pump_start_ms = m_axis_tdata[35:4];
                got.hour_of_day   = m_axis_tdata[40:36];
                results_seen++;
                if (cmd_due.size() == 0)
                begin
                    $error("result transaction with no prediction pending");
                    fail_count++;
                end
                else
                begin
                    want = cmd_due.pop_front();
                    check_field("heater_cmd", want.heater_cmd, got.heater_cmd);
                    check_field("fan_on", want.fan_on, got.fan_on);
                    check_field("pump_on", want.pump_on, got.pump_on);
                    check_field("lamp_on", want.lamp_on, got.lamp_on);
                    check_field("pump_start_ms", want.pump_start_ms, got.pump_start_ms);
                    check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
                end
                if (results_seen % 32 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, MaxIdle);
                if (results_seen == HoldAt)
                    rx_wait = HoldCycles;
            end
            else if (rx_wait != 0)
                rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if the bus goes silent for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || s_fire || m_fire || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("greenhouse_climate_controller verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        return tx_calm ? 0 : $urandom_range(0, MaxIdle);
    endfunction

    function automatic void add_step(input logic [31:0] now, input int temp, input bit tok,
                                     input int hum, input bit hok, input int soil,
                                     input int light);
        step_t s;
        s.now_ms         = now;
        s.temperature    = 11'(temp);
        s.temperature_ok = tok;
        s.humidity       = 10'(hum);
        s.humidity_ok    = hok;
        s.soil_raw       = 10'(soil);
        s.light_raw      = 10'(light);
        s.gap            = draw_gap();
        step_queue.push_back(s);
    endfunction

    // Mostly a clock that moves forward in small steps, with readings near
    // the current thresholds; now and then hour edges, wraps and raw noise.
    function automatic step_t random_step();
        step_t       s;
        int unsigned pick;
        int          t;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            wall_ms = wall_ms + $urandom_range(0, 1800);
        else if (pick < 18)
            wall_ms = wall_ms + HourMs - (wall_ms % HourMs) - $urandom_range(0, 3);
        else if (pick == 18)
            wall_ms = $urandom;
        else
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        s.now_ms = wall_ms;

        pick = $urandom_range(0, 9);
        if (pick < 6)
            t = ($urandom_range(0, 1) ? lim_temp_lo : lim_temp_hi)
                + int'($urandom_range(0, 30)) - 15;
        else if (pick < 8)
            t = int'($urandom_range(0, 1200)) - 400;
        else
            t = int'($urandom_range(0, 2047)) - 1024;
        s.temperature    = 11'(t);
        s.temperature_ok = ($urandom_range(0, 9) != 0);

        if ($urandom_range(0, 1))
            s.humidity = 10'(int'(lim_hum) + int'($urandom_range(0, 40)) - 20);
        else
            s.humidity = 10'($urandom);
        s.humidity_ok = ($urandom_range(0, 9) != 0);

        pick = $urandom_range(0, 2);
        if (pick == 0)
            s.soil_raw = 10'(int'(lim_dry) + int'($urandom_range(0, 16)) - 8);
        else if (pick == 1)
            s.soil_raw = 10'(int'(lim_wet) + int'($urandom_range(0, 16)) - 8);
        else
            s.soil_raw = 10'($urandom);

        // light is inverted inside, so aim at 1023 minus each lamp threshold
        pick = $urandom_range(0, 2);
        if (pick == 0)
            s.light_raw = LightFull - 10'(int'(lim_dark) + int'($urandom_range(0, 16)) - 8);
        else if (pick == 1)
            s.light_raw = LightFull - 10'(int'(lim_bright) + int'($urandom_range(0, 16)) - 8);
        else
            s.light_raw = 10'($urandom);

        s.gap = draw_gap();
        return s;
    endfunction

    // Register write, one per edge; shadow copy updated with the same masking.
    task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        reg_writes++;
        case (idx)
            REG_TEMP_MIN:     lim_temp_lo = int'($signed(val));
            REG_TEMP_MAX:     lim_temp_hi = int'($signed(val));
            REG_HUMIDITY_MAX: lim_hum     = val[9:0];
            REG_SOIL_DRY:     lim_dry     = val[9:0];
            REG_SOIL_WET:     lim_wet     = val[9:0];
            REG_LIGHT_DARK:   lim_dark    = val[9:0];
            REG_LIGHT_BRIGHT: lim_bright  = val[9:0];
            default:          ;
        endcase
    endtask

    // All seven thresholds; bit 10 of the 10-bit registers is random and must
    // be dropped by the block.
    task automatic apply_limits(input int tlo, input int thi, input int hum, input int dry,
                                input int wet, input int dk, input int br);
        write_reg(REG_TEMP_MIN, 11'(tlo));
        write_reg(REG_TEMP_MAX, 11'(thi));
        write_reg(REG_HUMIDITY_MAX, {1'($urandom_range(0, 1)), 10'(hum)});
        write_reg(REG_SOIL_DRY, {1'($urandom_range(0, 1)), 10'(dry)});
        write_reg(REG_SOIL_WET, {1'($urandom_range(0, 1)), 10'(wet)});
        write_reg(REG_LIGHT_DARK, {1'($urandom_range(0, 1)), 10'(dk)});
        write_reg(REG_LIGHT_BRIGHT, {1'($urandom_range(0, 1)), 10'(br)});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sampled at the falling edge so the driver and monitor have settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (step_queue.size() != 0 || s_axis_tvalid || cmd_due.size() != 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int tlo;
        int thi;
        int dry;
        int dk;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        // Directed steps at reset thresholds (260/270, 600, 400/500, 200/500).
        // Start-up fan window and its last millisecond; pump start latch; lamp on.
        add_step(32'd0, 250, 1, 300, 1, 450, 1023);
        add_step(32'd4999, -400, 1, 0, 1, 0, 0);
        // heater on-to-off opens the after-heat window; fan from heat and high humidity
        add_step(32'd5000, 800, 1, 1000, 1, 1023, 512);
        // last millisecond of the window, bad humidity replaced by 50.0
        add_step(32'd6999, 265, 1, 1023, 0, 450, 1000);
        add_step(32'd7000, 265, 1, 100, 1, 450, 1000);
        // vent window edges, pump dead band on both thresholds
        add_step(32'd7200000, 265, 1, 100, 1, 399, 1000);
        add_step(32'd21599999, 265, 1, 600, 1, 400, 1000);
        add_step(32'd21600000, 265, 1, 601, 1, 500, 1000);
        add_step(32'd21600001, 265, 1, 100, 1, 501, 1000);
        // night begins at 22:00 and ends at 06:00
        add_step(32'd50399999, 265, 1, 100, 1, 450, 0);
        add_step(32'd50400000, 265, 1, 100, 1, 450, 0);
        add_step(32'd79199999, 265, 1, 100, 1, 450, 0);
        add_step(32'd79200000, 265, 1, 100, 1, 450, 0);
        // top of the timestamp range, heater on exactly at temp_min
        add_step(32'hFFFF_FFFF, 260, 1, 601, 1, 0, 0);
        // out-of-range temperature turns the heater off; window then spans the wrap
        add_step(32'hFFFF_FC00, 1023, 1, 0, 1, 1023, 1023);
        add_step(32'h0000_0100, 265, 1, 0, 1, 450, 500);
        add_step(32'h0000_03CF, 265, 1, 0, 1, 450, 500);
        add_step(32'h0000_03D0, 265, 1, 0, 1, 450, 500);
        // most negative reading, then off exactly at temp_max
        add_step(32'h0000_0400, -1024, 1, 1023, 1, 1023, 512);
        add_step(32'h0000_0401, 270, 1, 0, 1, 1023, 512);
        // invalid temperature replaced by 20.0, which is below temp_min
        add_step(32'h0000_0402, 1023, 0, 0, 0, 1023, 512);
        add_step(32'h0000_0403, -1024, 0, 0, 1, 1023, 512);
        wall_ms = 32'h0000_0404;
        wait_drained();

        write_reg(RegSpare, 11'h7FF);
        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            case (ph)
                1:
                    // widest settings, hysteresis bands as wide as they go
                    apply_limits(-400, 800, 0, 0, 1023, 0, 1023);
                2:
                    // every pair crossed: the on/dry test has to win
                    apply_limits(800, -400, 1000, 1023, 0, 1023, 0);
                default:
                begin
                    tlo = int'($urandom_range(0, 1200)) - 400;
                    thi = $urandom_range(0, 3) != 0 ? tlo + int'($urandom_range(0, 40))
                                                    : int'($urandom_range(0, 1200)) - 400;
                    dry = $urandom_range(0, 1023);
                    dk  = $urandom_range(0, 1023);
                    apply_limits(tlo, thi, $urandom_range(0, 1000), dry,
                                 $urandom_range(0, 1) ? dry + int'($urandom_range(0, 100))
                                                      : int'($urandom_range(0, 1023)),
                                 dk,
                                 $urandom_range(0, 1) ? dk + int'($urandom_range(0, 300))
                                                      : int'($urandom_range(0, 1023)));
                end
            endcase
            for (int i = 0; i < PhaseSteps; i++)
            begin
                if (i % 16 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                step_queue.push_back(random_step());
            end
            wait_drained();
        end

        $display("%0d control steps checked, %0d register writes over %0d threshold sets,",
                 steps_taken, reg_writes, PhaseCount + 1);
        $display("random stalls on both sides and one %0d-cycle output hold-off", HoldCycles);
        if (fail_count == 0)
            $display("greenhouse_climate_controller verification clean");
        else
            $display("greenhouse_climate_controller verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gcc_pkg.sv
hdl/gcc_ctrl_core.sv
hdl/greenhouse_climate_controller.sv
sim/tb.sv
